### rtl/half_float_convert_assert.svh
// assertion macros shared by the checker of half_float_convert
// no dependencies
`ifndef HALF_FLOAT_CONVERT_ASSERT_SVH
`define HALF_FLOAT_CONVERT_ASSERT_SVH
`define HFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define HFC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");
`endif

### rtl/hfc_pkg.sv
// types and constants for the half/single float converter
// no dependencies
package hfc_pkg;
  localparam logic CMD_TO_HALF = 1'b0;
  localparam logic CMD_TO_SINGLE = 1'b1;
  typedef struct packed {
    logic [31:0] operand_bits;
    logic        command;
  } hfc_in_t;
endpackage

### rtl/half_float_convert.sv
// half_float_convert: single to half and half to single bit pattern conversion
// depends on hfc_pkg
// beats pass input then result register; one per cycle unless out_tready stalls
// the input register and the result register each move when the stage ahead frees
// synchronous active-low reset clears both valid flags; payload registers keep no reset
module half_float_convert
  import hfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // operand_bits[31:0]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // result_bits[31:0]
);
  logic        s1_vld_r, out_vld_r;
  hfc_in_t     s1_r;
  logic [31:0] res_r, res_nxt;
  logic        s1_go, out_go;

  assign out_go    = !out_vld_r || out_tready;
  assign s1_go     = !s1_vld_r || out_go;
  assign in_tready = s1_go;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_go) s1_vld_r <= in_tvalid;
      if (out_go) out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && in_tvalid) s1_r <= '{operand_bits: in_tdata, command: in_tuser};
    if (out_go && s1_vld_r) res_r <= res_nxt;
  end

  // narrowing
  logic [15:0] n_res;
  logic        sgn;
  logic [8:0]  e9;
  logic [22:0] man;
  logic [23:0] m24;
  logic [4:0]  sh;
  logic [23:0] sub_h, sub_rem, sub_half;
  logic [15:0] nh;
  logic [12:0] rem13;
  // widening
  logic [31:0] w_res;
  logic [4:0]  he;
  logic [9:0]  hm, nm;
  logic [3:0]  lz;

  always_comb begin
    sgn   = s1_r.operand_bits[31];
    man   = s1_r.operand_bits[22:0];
    e9    = {1'b0, s1_r.operand_bits[30:23]};
    m24   = {1'b1, man};
    sh    = '0;
    sub_h = '0; sub_rem = '0; sub_half = '0;
    nh    = '0;
    rem13 = man[12:0];
    if (e9 >= 9'd143) begin
      n_res = {sgn, 15'h7c00};
    end else if (e9 <= 9'd112) begin
      if (e9 < 9'd102) begin
        n_res = {sgn, 15'd0};
      end else begin
        sh       = 5'(9'd126 - e9);
        sub_h    = m24 >> sh;
        sub_rem  = m24 & ((24'd1 << sh) - 24'd1);
        sub_half = 24'd1 << (sh - 5'd1);
        if (sub_rem > sub_half || (sub_rem == sub_half && sub_h[0]))
          sub_h = sub_h + 24'd1;
        n_res = {sgn, sub_h[14:0]};
      end
    end else begin
      nh = {1'b0, 5'(e9 - 9'd112), man[22:13]};
      if (rem13 > 13'h1000 || (rem13 == 13'h1000 && nh[0])) nh = nh + 16'd1;
      if (nh[14:10] == 5'h1f) n_res = {sgn, 15'h7c00};
      else n_res = {sgn, nh[14:0]};
    end
  end

  always_comb begin
    he = s1_r.operand_bits[14:10];
    hm = s1_r.operand_bits[9:0];
    lz = 4'd0;
    for (int i = 0; i < 10; i++)
      if (hm[i]) lz = 4'(10 - i);
    nm = 10'(hm << lz);
    if (he == 5'd0) begin
      if (hm == '0) w_res = {s1_r.operand_bits[15], 31'd0};
      else w_res = {s1_r.operand_bits[15], 8'(8'd113 - {4'd0, lz}), nm, 13'd0};
    end else if (he == 5'h1f) begin
      w_res = {s1_r.operand_bits[15], 8'hff, hm, 13'd0};
    end else begin
      w_res = {s1_r.operand_bits[15], 8'({3'd0, he} + 8'd112), hm, 13'd0};
    end
  end

  assign res_nxt = (s1_r.command == CMD_TO_SINGLE) ? w_res : {16'd0, n_res};
endmodule

### rtl/hfc_checker.sv
// port-level checker for half_float_convert, bound into every half_float_convert instance
// depends on half_float_convert_assert.svh
`include "half_float_convert_assert.svh"
module hfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  `HFC_ASSERT(out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `HFC_ASSERT_RST(rst_clear, !rst_n |=> !out_tvalid)
  `HFC_ASSERT(ready_when_drained, out_tready |-> in_tready)
  `HFC_ASSERT(beat_arrives, in_tvalid && in_tready && out_tready ##1 out_tready |=> out_tvalid)
endmodule

bind half_float_convert hfc_checker u_hfc_checker (.*);

### sim/tb_top.sv
// testbench for half_float_convert: drives single/half conversion beats with random gaps
// and checks each result against an in-bench converter; depends on hfc_pkg and the rtl
module tb_top;
  import hfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class conv_scoreboard;
    logic [31:0] pending[$];
    int errors;

    function automatic logic [31:0] to_half(logic [31:0] u);
      logic [31:0] sgn, mant, h, rem, m, sh, hw;
      int e;
      sgn = (u >> 16) & 32'h8000;
      e = int'(u[30:23]) - 127 + 15;
      mant = u & 32'h7fffff;
      if (e >= 31) return sgn | 32'h7c00;
      if (e <= 0) begin
        if (e < -10) return sgn;
        m = mant | 32'h800000;
        sh = 14 - e;
        h = m >> sh;
        rem = m & ((32'd1 << sh) - 1);
        hw = 32'd1 << (sh - 1);
        if (rem > hw || (rem == hw && h[0])) h = h + 1;
        return sgn | h;
      end
      h = (e << 10) | (mant >> 13);
      rem = mant & 32'h1fff;
      if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h = h + 1;
      if ((h & 32'h7c00) == 32'h7c00) return sgn | 32'h7c00;
      return sgn | h;
    endfunction

    function automatic logic [31:0] to_single(logic [15:0] h);
      logic [31:0] sgn, m;
      logic [4:0] e;
      int sh;
      sgn = {h[15], 31'd0};
      e = h[14:10];
      m = {22'd0, h[9:0]};
      if (e == 0) begin
        if (m == 0) return sgn;
        sh = 0;
        while (m[10] == 0 && sh < 11) begin
          m = m << 1;
          sh++;
        end
        m = m & 32'h3ff;
        return sgn | ((113 - sh) << 23) | (m << 13);
      end
      if (e == 5'h1f) return sgn | 32'h7f800000 | (m << 13);
      return sgn | ((e + 112) << 23) | (m << 13);
    endfunction

    function void note_input(logic cmd, logic [31:0] op);
      pending.push_back(cmd == CMD_TO_SINGLE ? to_single(op[15:0]) : to_half(op));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: result_bits mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tuser = 0, out_tready = 0;
  logic [31:0] in_tdata = 0;
  logic in_tready, out_tvalid;
  logic [31:0] out_tdata;
  logic stim_done = 0;
  int hold_off = 0;
  conv_scoreboard sb = new();

  half_float_convert dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  task automatic send_beat(logic cmd, logic [31:0] op, int gap);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= op;
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, op);
  endtask

  task automatic send_random(int gap);
    logic [31:0] op;
    logic cmd;
    cmd = 1'($urandom_range(0, 1));
    op = $urandom;
    case ($urandom_range(0, 5))
      0: op[30:23] = 8'($urandom_range(100, 145));
      1: op[30:23] = 8'($urandom_range(101, 113));
      2: op[30:23] = 8'($urandom_range(140, 145));
      3: op[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      4: op[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0fff;
      default: ;
    endcase
    if (cmd == CMD_TO_SINGLE && $urandom_range(0, 3) == 0)
      op[14:10] = $urandom_range(0, 1) ? 5'h1f : 5'h00;
    send_beat(cmd, op, gap);
  endtask

  initial begin
    logic [31:0] dirs[$];
    dirs = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h7f800000, 32'hff800000,
             32'h7fc00001, 32'h477fe000, 32'h477ff000, 32'h47800000, 32'h33000000,
             32'h33000001, 32'h387fe000, 32'h38800000, 32'h3f801000, 32'h3f803000,
             32'hffffffff, 32'h3f800000};
    repeat (12) @(posedge clk);
    rst_n <= 1;
    foreach (dirs[i]) send_beat(CMD_TO_HALF, dirs[i], 0);
    foreach (dirs[i]) send_beat(CMD_TO_SINGLE, {dirs[i][31:16] ^ 16'hffff, dirs[i][31:16]}, 0);
    send_beat(CMD_TO_SINGLE, 32'h00000001, 0);
    send_beat(CMD_TO_SINGLE, 32'h000003ff, 0);
    send_beat(CMD_TO_SINGLE, 32'hffff7fff, 0);
    hold_off = 60;
    repeat (40) send_random(0);
    for (int i = 0; i < 1900; i++) begin
      if (i == 900) begin
        in_tvalid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send_random(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
    end
    in_tvalid <= 0;
    stim_done <= 1;
  end

  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      if (hold_off > 0) begin
        out_tready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
    end
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule
